[hdl/ilb_pkg.sv]
// ----------------------------------------------------------------------------
// ilb_pkg
// Shared sizes, command and status codes, and the bundles passed between the
// list sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package ilb_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    // fixed field widths at the ports
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam int CMP_W   = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND  = 3'd0,
        CMD_INSERT  = 3'd1,
        CMD_ERASE   = 3'd2,
        CMD_REVERSE = 3'd3,
        CMD_READ    = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [STORE_W-1:0] wdata;
        logic [ADDR_W-1:0]  raddr;
    } mem_req_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_data;
        logic [COUNT_W-1:0] count;
        status_t            status;
    } result_t;

endpackage

`default_nettype wire

[hdl/ilb_ram.sv]
// ----------------------------------------------------------------------------
// ilb_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ilb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[hdl/ilb_seq.sv]
// ----------------------------------------------------------------------------
// ilb_seq
// Command sequencer: range checks, entry count, and the move loops for
// insert, erase and reverse, at most one RAM read and one RAM write per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ilb_seq (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ilb_pkg::CMD_W-1:0]     cmd,
    input  logic [ilb_pkg::IDX_W-1:0]     index,
    input  logic [ilb_pkg::VALUE_W-1:0]   value,
    input  logic [ilb_pkg::STORE_W-1:0]   rdata,
    output ilb_pkg::mem_req_t             mem,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ilb_pkg::result_t              res
);

    import ilb_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_SHIFT  = 10'b00_0000_0010,
        S_FLUSH  = 10'b00_0000_0100,
        S_PUT    = 10'b00_0000_1000,
        S_READ   = 10'b00_0001_0000,
        S_REV_RI = 10'b00_0010_0000,
        S_REV_RJ = 10'b00_0100_0000,
        S_REV_WI = 10'b00_1000_0000,
        S_REV_WJ = 10'b01_0000_0000,
        S_RESP   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               wr_pend_reg, wr_pend_next;

    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [ADDR_W-1:0]  src_reg, src_next;     // shift pointer / reverse low end
    logic [ADDR_W-1:0]  stop_reg, stop_next;   // shift end / reverse high end
    logic [ADDR_W-1:0]  wr_addr_reg, wr_addr_next;
    logic [STORE_W-1:0] val_reg, val_next;
    logic [STORE_W-1:0] hold_reg, hold_next;
    logic [STORE_W-1:0] rd_data_reg, rd_data_next;
    logic               ins_reg, ins_next;
    status_t            status_reg, status_next;

    logic [CMP_W-1:0]   idx_x;
    logic [CMP_W-1:0]   cnt_x;
    logic [CNT_W-1:0]   cnt_m1;
    logic               full;

    assign idx_x  = CMP_W'(index);
    assign cnt_x  = CMP_W'(count_reg);
    assign cnt_m1 = count_reg - CNT_W'(1);
    assign full   = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        src_next     = src_reg;
        stop_next    = stop_reg;
        wr_addr_next = wr_addr_reg;
        val_next     = val_reg;
        hold_next    = hold_reg;
        rd_data_next = rd_data_reg;
        ins_next     = ins_reg;
        status_next  = status_reg;
        wr_pend_next = (state_reg == S_SHIFT);

        // a word read in the previous shift cycle is written in this one
        mem.we    = wr_pend_reg;
        mem.waddr = wr_addr_reg;
        mem.wdata = rdata;
        mem.raddr = src_reg;

        case (state_reg)
            S_IDLE:
            begin
                mem.raddr = ADDR_W'(index);
                if (in_valid)
                begin
                    val_next     = value[STORE_W-1:0];
                    rd_data_next = '0;
                    status_next  = ST_OK;
                    state_next   = S_RESP;
                    case (cmd_t'(cmd))
                        CMD_APPEND:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                idx_next   = ADDR_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                                state_next = S_PUT;
                            end
                        end
                        CMD_INSERT:
                        begin
                            if (idx_x > cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                idx_next   = ADDR_W'(index);
                                count_next = count_reg + CNT_W'(1);
                                ins_next   = 1'b1;
                                if (idx_x == cnt_x)
                                begin
                                    state_next = S_PUT;
                                end
                                else
                                begin
                                    src_next   = ADDR_W'(cnt_m1);
                                    stop_next  = ADDR_W'(index);
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        CMD_ERASE:
                        begin
                            if (idx_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                                ins_next   = 1'b0;
                                if ((idx_x + CMP_W'(1)) < cnt_x)
                                begin
                                    src_next   = ADDR_W'(index) + ADDR_W'(1);
                                    stop_next  = ADDR_W'(cnt_m1);
                                    state_next = S_SHIFT;
                                end
                            end
                        end
                        CMD_REVERSE:
                        begin
                            if (count_reg >= CNT_W'(2))
                            begin
                                src_next   = '0;
                                stop_next  = ADDR_W'(cnt_m1);
                                state_next = S_REV_RI;
                            end
                        end
                        CMD_READ:
                        begin
                            if (idx_x >= cnt_x)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_READ;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_SHIFT:
            begin
                mem.raddr    = src_reg;
                wr_addr_next = ins_reg ? (src_reg + ADDR_W'(1)) : (src_reg - ADDR_W'(1));
                if (src_reg == stop_reg)
                begin
                    state_next = S_FLUSH;
                end
                else
                begin
                    src_next = ins_reg ? (src_reg - ADDR_W'(1)) : (src_reg + ADDR_W'(1));
                end
            end
            S_FLUSH:
            begin
                state_next = ins_reg ? S_PUT : S_RESP;
            end
            S_PUT:
            begin
                mem.we     = 1'b1;
                mem.waddr  = idx_reg;
                mem.wdata  = val_reg;
                state_next = S_RESP;
            end
            S_READ:
            begin
                rd_data_next = rdata;
                state_next   = S_RESP;
            end
            S_REV_RI:
            begin
                mem.raddr  = src_reg;
                state_next = S_REV_RJ;
            end
            S_REV_RJ:
            begin
                mem.raddr  = stop_reg;
                hold_next  = rdata;
                state_next = S_REV_WI;
            end
            S_REV_WI:
            begin
                mem.we     = 1'b1;
                mem.waddr  = src_reg;
                mem.wdata  = rdata;
                state_next = S_REV_WJ;
            end
            S_REV_WJ:
            begin
                mem.we    = 1'b1;
                mem.waddr = stop_reg;
                mem.wdata = hold_reg;
                src_next  = src_reg + ADDR_W'(1);
                stop_next = stop_reg - ADDR_W'(1);
                // another pair remains while the current ends are more than two apart
                if (({1'b0, src_reg} + (ADDR_W + 1)'(2)) < {1'b0, stop_reg})
                begin
                    state_next = S_REV_RI;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            wr_pend_reg <= wr_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        src_reg     <= src_next;
        stop_reg    <= stop_next;
        wr_addr_reg <= wr_addr_next;
        val_reg     <= val_next;
        hold_reg    <= hold_next;
        rd_data_reg <= rd_data_next;
        ins_reg     <= ins_next;
        status_reg  <= status_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign res_valid     = (state_reg == S_RESP);
    assign res.read_data = VALUE_W'(rd_data_reg);
    assign res.count     = COUNT_W'(count_reg);
    assign res.status    = status_reg;

endmodule

`default_nettype wire

[hdl/indexed_list_buffer.sv]
// Commands pass through the sequencer one at a time, with at most one RAM read and
// one RAM write per cycle; the next command can be accepted in the cycle after the
// previous result is parked in the output register.
// Reset (async, active low) empties the list; stored words stay undefined.
`default_nettype none

module indexed_list_buffer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [ilb_pkg::CMD_W-1:0]   cmd,
    input  logic [ilb_pkg::IDX_W-1:0]   index,
    input  logic [ilb_pkg::VALUE_W-1:0] value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ilb_pkg::VALUE_W-1:0] read_data,
    output logic [ilb_pkg::COUNT_W-1:0] count,
    output logic [ilb_pkg::STATUS_W-1:0] status
);

    import ilb_pkg::*;

    mem_req_t           mem;
    logic [STORE_W-1:0] rdata;
    logic               res_valid;
    logic               res_ready;
    result_t            res;
    logic               load;

    logic               out_valid_reg, out_valid_next;
    result_t            out_reg;

    ilb_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .index     (index),
        .value     (value),
        .rdata     (rdata),
        .mem       (mem),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    ilb_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (STORE_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rdata)
    );

    // output register frees the sequencer once the result is parked here
    assign res_ready = !out_valid_reg || out_ready;
    assign load      = res_valid && res_ready;

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_reg.read_data;
    assign count     = out_reg.count;
    assign status    = out_reg.status;

endmodule

`default_nettype wire

[hdl/ilb_checker.sv]
// ----------------------------------------------------------------------------
// ilb_checker
// Port-level checks on the list buffer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilb_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [ilb_pkg::VALUE_W-1:0]  read_data,
    input  logic [ilb_pkg::COUNT_W-1:0]  count,
    input  logic [ilb_pkg::STATUS_W-1:0] status
);

    import ilb_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data)
            && $stable(count) && $stable(status))
        else $error("result changed while stalled");

    // not ready right after each command transfer
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after a command transfer");

    a_err_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> read_data == '0)
        else $error("nonzero read data on an error result");

    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> count <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> count == COUNT_W'(CAPACITY))
        else $error("full status with room left");

endmodule

bind indexed_list_buffer ilb_checker u_ilb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .count     (count),
    .status    (status)
);

`default_nettype wire
